// File: sv/lcpr_pkg.sv
package lcpr_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DFLT = 256;
  localparam logic [7:0]  SYNC_BYTE_RST      = 8'hAA;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_READ = 2'd1,
    OP_ACK  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_TAKEN = 3'd1,
    EV_GOOD  = 3'd2,
    EV_BAD   = 3'd3,
    EV_ZERO  = 3'd4
  } ev_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       packet_ready;
    logic [7:0] packet_length;
    logic [7:0] read_data;
  } out_beat_t;

  // per-item status from parser to output stage; read data joins later
  typedef struct packed {
    ev_t        ev;
    logic       ready;
    logic [7:0] length;
    logic       rd_en;
  } res_t;

endpackage

// File: sv/lcpr_mem.sv
module lcpr_mem #(
  parameter int unsigned WORDS = 512,
  parameter int unsigned AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [WORDS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/lcpr_parser.sv
module lcpr_parser #(
  parameter int unsigned PAYLOAD_DEPTH = 256,
  parameter int unsigned AW            = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              accept,
  input  lcpr_pkg::in_beat_t in_beat,
  output lcpr_pkg::res_t    res,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr
);
  import lcpr_pkg::*;

  localparam int unsigned    IW       = $clog2(PAYLOAD_DEPTH);
  localparam logic [8:0]     DEPTH_W  = 9'(PAYLOAD_DEPTH);
  localparam logic [AW-1:0]  BANK_OFS = AW'(PAYLOAD_DEPTH);

  phase_t     phase_r, phase_nxt;
  logic [7:0] sync_r;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       pub_bank_r, pub_bank_nxt;
  logic [7:0] pub_len_r, pub_len_nxt;
  logic       ready_r, ready_nxt;
  ev_t        ev;
  logic [7:0] cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r     <= SYNC_BYTE_RST;
      len_r      <= '0;
      cnt_r      <= '0;
      sum_r      <= '0;
      pub_bank_r <= 1'b0;
      pub_len_r  <= '0;
      ready_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        sync_r <= cfg_wdata;
      end
      len_r      <= len_nxt;
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      pub_bank_r <= pub_bank_nxt;
      pub_len_r  <= pub_len_nxt;
      ready_r    <= ready_nxt;
    end
  end

  assign cnt_inc = 8'(cnt_r + 8'd1);

  always_comb begin
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    pub_bank_nxt = pub_bank_r;
    pub_len_nxt  = pub_len_r;
    ready_nxt    = ready_r;
    ev           = EV_NONE;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    if (accept) begin
      case (in_beat.op)
        OP_RX: begin
          case (phase_r)
            PH_LEN_HI: begin
              phase_nxt = PH_LEN_LO;
              ev        = EV_TAKEN;
            end
            PH_LEN_LO: begin
              if (in_beat.rx_byte == 8'd0) begin
                phase_nxt = PH_HUNT;
                ev        = EV_ZERO;
              end else begin
                len_nxt   = in_beat.rx_byte;
                cnt_nxt   = '0;
                sum_nxt   = in_beat.rx_byte;
                phase_nxt = PH_PAYLOAD;
                ev        = EV_TAKEN;
              end
            end
            PH_PAYLOAD: begin
              wr_en   = ({1'b0, cnt_r} < DEPTH_W);
              sum_nxt = 8'(sum_r + in_beat.rx_byte);
              cnt_nxt = cnt_inc;
              if (cnt_inc == len_r) begin
                phase_nxt = PH_CHECK;
              end
              ev = EV_TAKEN;
            end
            PH_CHECK: begin
              phase_nxt = PH_HUNT;
              if (in_beat.rx_byte == 8'(8'd0 - sum_r)) begin
                pub_bank_nxt = ~pub_bank_r;
                pub_len_nxt  = len_r;
                ready_nxt    = 1'b1;
                ev           = EV_GOOD;
              end else begin
                ready_nxt = 1'b0;
                ev        = EV_BAD;
              end
            end
            default: begin
              if (in_beat.rx_byte == sync_r) begin
                phase_nxt = PH_LEN_HI;
                ev        = EV_TAKEN;
              end else begin
                phase_nxt = PH_HUNT;
              end
            end
          endcase
        end
        OP_READ: begin
          rd_en = (in_beat.read_index < pub_len_r) &&
                  ({1'b0, in_beat.read_index} < DEPTH_W);
        end
        OP_ACK: begin
          ready_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // receive bank is the one not published; reads only touch the published bank
  assign wr_addr = (pub_bank_r ? '0 : BANK_OFS) + AW'(cnt_r[IW-1:0]);
  assign wr_data = in_beat.rx_byte;
  assign rd_addr = (pub_bank_r ? BANK_OFS : '0) + AW'(in_beat.read_index[IW-1:0]);

  assign res.ev     = ev;
  assign res.ready  = ready_nxt;
  assign res.length = pub_len_nxt;
  assign res.rd_en  = rd_en;

  a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> cnt_r < len_r)
    else $error("payload count reached length without leaving payload phase");

  a_good_swaps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ev == EV_GOOD |=> ready_r && pub_bank_r != $past(pub_bank_r))
    else $error("good frame did not publish");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ev == EV_ZERO |=> phase_r == PH_HUNT && $stable(pub_len_r))
    else $error("zero length frame not dropped");

endmodule

// File: sv/lcpr_outq.sv
module lcpr_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lcpr_pkg::res_t      res,
  input  logic [7:0]          mem_q,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output lcpr_pkg::out_beat_t out_data
);
  import lcpr_pkg::*;

  logic      a_valid_r, a_valid_nxt;
  res_t      a_res_r;
  logic      o_valid_r, o_valid_nxt;
  out_beat_t o_data_r;
  logic      a_move;

  assign a_move      = a_valid_r && (!o_valid_r || !out_stall);
  assign in_stall    = a_valid_r && !a_move;
  assign a_valid_nxt = push || (a_valid_r && !a_move);
  assign o_valid_nxt = a_move || (o_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      a_res_r <= res;
    end
    if (a_move) begin
      o_data_r.event_res     <= a_res_r.ev;
      o_data_r.packet_ready  <= a_res_r.ready;
      o_data_r.packet_length <= a_res_r.length;
      o_data_r.read_data     <= a_res_r.rd_en ? mem_q : 8'd0;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !a_move |=> a_valid_r && $stable(a_res_r))
    else $error("held result lost");

  a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
    a_move |=> o_valid_r)
    else $error("moved result not presented");

endmodule

// File: sv/length_checksum_packet_receiver_core.sv
// channel | ports                                 | handshake
// in      | in_valid, in_stall, in_data (in_beat)   | valid & !stall
// out     | out_valid, out_stall, out_data (out_beat)| valid & !stall
// cfg     | cfg_valid, cfg_ready, cfg_data (sync)   | valid & ready
// One item per cycle sustained while out_stall is low; otherwise in_stall holds the input.
// The accepted beat's result and payload RAM read go into the first result slot, then
// into the output register that drives out_valid.
// Two result slots: one beat is taken while a finished one waits on out_stall.
// rst_n synchronous: hunting, ready clear, sync byte 0xAA; payload RAM not cleared.
// cfg_ready is always high.
module length_checksum_packet_receiver_core #(
  parameter int unsigned PAYLOAD_DEPTH = lcpr_pkg::PAYLOAD_DEPTH_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcpr_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lcpr_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import lcpr_pkg::*;

  localparam int unsigned WORDS = 2 * PAYLOAD_DEPTH;
  localparam int unsigned AW    = $clog2(WORDS);

  logic          accept;
  res_t          res;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    mem_q;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  lcpr_parser #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
    .AW           (AW)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_wdata(cfg_data),
    .accept   (accept),
    .in_beat  (in_data),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  lcpr_mem #(
    .WORDS(WORDS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(mem_q)
  );

  lcpr_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .res      (res),
    .mem_q    (mem_q),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// File: test/tb_length_checksum_packet_receiver_core.sv
`timescale 1ns / 100ps

module tb_length_checksum_packet_receiver_core;
  import lcpr_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_beat_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  length_checksum_packet_receiver_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver state as the predictor sees it
  logic [7:0] sync_sh   = SYNC_BYTE_RST;
  phase_t     rx_phase  = PH_HUNT;
  logic [7:0] frame_len = '0;
  logic [7:0] byte_cnt  = '0;
  logic [7:0] csum      = '0;
  logic [7:0] bank_mem [0:511];
  logic       pub_bank  = 1'b0;
  logic [7:0] pub_len   = '0;
  logic       pkt_ready = 1'b0;

  in_beat_t   stim_q [$];
  out_beat_t  resp_q [$];
  out_beat_t  want;
  int         stim_n = 0;
  int         err_n = 0;
  logic [7:0] gen_sync = SYNC_BYTE_RST;

  logic       in_taken = 1'b0;
  logic       out_taken = 1'b0;
  logic       cfg_taken = 1'b0;
  int         in_gap = 0;
  int         out_wait = 0;
  bit         burst_in = 1'b0;
  bit         burst_out = 1'b0;

  function automatic out_beat_t predict_resp(in_beat_t b);
    out_beat_t r;
    r = '0;
    case (b.op)
      OP_RX: begin
        case (rx_phase)
          PH_LEN_HI: begin
            rx_phase = PH_LEN_LO;
            r.event_res = EV_TAKEN;
          end
          PH_LEN_LO: begin
            if (b.rx_byte == 8'd0) begin
              rx_phase = PH_HUNT;
              r.event_res = EV_ZERO;
            end else begin
              frame_len = b.rx_byte;
              byte_cnt = '0;
              csum = b.rx_byte;
              rx_phase = PH_PAYLOAD;
              r.event_res = EV_TAKEN;
            end
          end
          PH_PAYLOAD: begin
            bank_mem[{~pub_bank, byte_cnt}] = b.rx_byte;
            csum = csum + b.rx_byte;
            byte_cnt = byte_cnt + 8'd1;
            if (byte_cnt == frame_len) rx_phase = PH_CHECK;
            r.event_res = EV_TAKEN;
          end
          PH_CHECK: begin
            rx_phase = PH_HUNT;
            if (b.rx_byte == 8'd0 - csum) begin
              pub_bank = ~pub_bank;
              pub_len = frame_len;
              pkt_ready = 1'b1;
              r.event_res = EV_GOOD;
            end else begin
              pkt_ready = 1'b0;
              r.event_res = EV_BAD;
            end
          end
          default: begin
            if (b.rx_byte == sync_sh) begin
              rx_phase = PH_LEN_HI;
              r.event_res = EV_TAKEN;
            end else begin
              rx_phase = PH_HUNT;
              r.event_res = EV_NONE;
            end
          end
        endcase
      end
      OP_READ: begin
        if (b.read_index < pub_len) r.read_data = bank_mem[{pub_bank, b.read_index}];
      end
      OP_ACK: pkt_ready = 1'b0;
      default: ;
    endcase
    r.packet_ready = pkt_ready;
    r.packet_length = pub_len;
    return r;
  endfunction

  function automatic void push_beat(op_t op, logic [7:0] rx, logic [7:0] idx, bit counted);
    in_beat_t b;
    b.op = op;
    b.rx_byte = rx;
    b.read_index = idx;
    stim_q.push_back(b);
    if (counted) stim_n++;
  endfunction

  function automatic void push_rx(logic [7:0] rx);
    push_beat(OP_RX, rx, 8'($urandom), 1'b1);
  endfunction

  function automatic void push_side();
    logic [7:0] idx;
    idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    case ($urandom_range(0, 5))
      0, 1, 2: push_beat(OP_READ, 8'($urandom), idx, 1'b1);
      3, 4:    push_beat(OP_ACK, 8'($urandom), idx, 1'b1);
      default: push_beat(OP_NOP, 8'($urandom), idx, 1'b0);
    endcase
  endfunction

  function automatic void push_frame(logic [7:0] len, bit good);
    logic [7:0] sum;
    logic [7:0] d;
    sum = len;
    push_rx(gen_sync);
    push_rx(8'($urandom));
    push_rx(len);
    for (int i = 0; i < len; i++) begin
      d = ($urandom_range(0, 15) == 0) ? gen_sync : 8'($urandom);
      push_rx(d);
      sum = sum + d;
      if ($urandom_range(0, 19) == 0) push_side();
    end
    if (len != 0) begin
      if (good) push_rx(8'd0 - sum);
      else push_rx((8'd0 - sum) ^ 8'($urandom_range(1, 255)));
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (stim_q.size() != 0 || in_valid || resp_q.size() != 0);
  endtask

  task automatic write_sync(input logic [7:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    gen_sync = v;
  endtask

  // input beats
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        in_data <= stim_q.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) burst_in <= !burst_in;
        in_gap <= burst_in ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 63) == 0) burst_out = !burst_out;
      out_wait = burst_out ? 0 : $urandom_range(0, 9);
    end else if (out_wait != 0 && out_valid) begin
      out_wait = out_wait - 1;
    end
    out_stall <= (out_wait != 0);
  end

  always @(posedge clk) begin
    in_taken  <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (resp_q.size() == 0) begin
          err_n++;
          if (err_n <= 10)
            $display("unexpected beat at %0t: ev=%0d rdy=%0b len=%0d data=%02h", $time,
                     out_data.event_res, out_data.packet_ready, out_data.packet_length,
                     out_data.read_data);
        end else begin
          want = resp_q.pop_front();
          if (want.event_res !== out_data.event_res ||
              want.packet_ready !== out_data.packet_ready ||
              want.packet_length !== out_data.packet_length ||
              want.read_data !== out_data.read_data) begin
            err_n++;
            if (err_n <= 10)
              $display({"mismatch at %0t: exp ev=%0d rdy=%0b len=%0d data=%02h, ",
                        "got ev=%0d rdy=%0b len=%0d data=%02h"},
                       $time, want.event_res, want.packet_ready, want.packet_length,
                       want.read_data, out_data.event_res, out_data.packet_ready,
                       out_data.packet_length, out_data.read_data);
          end
        end
      end
      if (cfg_valid && cfg_ready) sync_sh = cfg_data;
      if (in_valid && !in_stall) resp_q.push_back(predict_resp(in_data));
    end
  end

  logic [7:0] sync_set [0:4];
  int         goal;
  int         pick;
  logic [7:0] flen_g;

  initial begin
    sync_set[0] = SYNC_BYTE_RST;
    sync_set[1] = 8'h00;
    sync_set[2] = 8'hFF;
    sync_set[3] = 8'($urandom_range(1, 254));
    sync_set[4] = SYNC_BYTE_RST;

    // directed: idle ops, non-sync noise, sync byte as payload, reads past
    // length, zero length, bad checksum
    push_beat(OP_NOP, 8'hFF, 8'hFF, 1'b1);
    push_beat(OP_ACK, 8'h00, 8'h00, 1'b1);
    push_beat(OP_READ, 8'h00, 8'h00, 1'b1);
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(SYNC_BYTE_RST);
    push_rx(8'hFF);
    push_rx(8'h01);
    push_rx(SYNC_BYTE_RST);
    push_rx(8'd0 - (8'd1 + SYNC_BYTE_RST));
    push_beat(OP_READ, 8'hFF, 8'h00, 1'b1);
    push_beat(OP_READ, 8'h00, 8'h01, 1'b1);
    push_beat(OP_READ, 8'h00, 8'hFF, 1'b1);
    push_beat(OP_ACK, 8'hFF, 8'hFF, 1'b1);
    push_frame(8'd0, 1'b1);
    push_frame(8'd2, 1'b0);
    push_beat(OP_READ, 8'h00, 8'h00, 1'b1);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 5; p++) begin
      if (p != 0) begin
        wait_drained();
        repeat (3) @(negedge clk);
        write_sync(sync_set[p]);
      end
      goal = stim_n + 400;
      while (stim_n < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          flen_g = 8'($urandom_range(0, 99));
          if (flen_g < 1) flen_g = 8'd255;
          else if (flen_g < 4) flen_g = 8'($urandom_range(17, 254));
          else flen_g = 8'($urandom_range(1, 16));
          push_frame(flen_g, $urandom_range(0, 9) != 0);
        end else if (pick < 60) begin
          push_frame(8'd0, 1'b1);
        end else if (pick < 85) begin
          push_side();
        end else begin
          repeat ($urandom_range(1, 4)) push_beat(OP_RX, 8'($urandom), 8'($urandom), 1'b0);
        end
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (err_n == 0 && resp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

// File: length_checksum_packet_receiver_core.f
sv/lcpr_pkg.sv
sv/lcpr_mem.sv
sv/lcpr_parser.sv
sv/lcpr_outq.sv
sv/length_checksum_packet_receiver_core.sv
test/tb_length_checksum_packet_receiver_core.sv
